/* hw/rtl/ult_pkg.sv */
// Package: shared constants, types and Latin-9 table functions for the transcoder.
`timescale 1ns / 1ps

package ult_pkg;

    localparam int unsigned MAP_SLOTS = 32;   // dynamic slots, 0..31
    localparam int unsigned SLOT_W    = 5;    // slot index bits inside byte 0x80..0x9F
    localparam int unsigned NEXT_W    = 6;    // free-slot counter, holds MAP_SLOTS itself
    localparam int unsigned CODE_W    = 31;

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        logic used;
        logic hit;
    } t_cell_stat;

    // Code point of a Latin-9 byte 0xA0..0xFF.
    function automatic t_code fixed_code(input logic [7:0] b);
        t_code c;
        begin
            case (b)
                8'hA4:   c = 31'h20AC;
                8'hA6:   c = 31'h0160;
                8'hA8:   c = 31'h0161;
                8'hB4:   c = 31'h017D;
                8'hB8:   c = 31'h017E;
                8'hBC:   c = 31'h0152;
                8'hBD:   c = 31'h0153;
                8'hBE:   c = 31'h0178;
                default: c = {23'd0, b};
            endcase
            return c;
        end
    endfunction

    // Latin-9 byte of a code point above 0xFF, zero when there is none.
    function automatic logic [7:0] fixed_byte(input t_code c);
        logic [7:0] b;
        begin
            case (c)
                31'h20AC: b = 8'hA4;
                31'h0160: b = 8'hA6;
                31'h0161: b = 8'hA8;
                31'h017D: b = 8'hB4;
                31'h017E: b = 8'hB8;
                31'h0152: b = 8'hBC;
                31'h0153: b = 8'hBD;
                31'h0178: b = 8'hBE;
                default:  b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

/* hw/rtl/ult_in_if.sv */
// Interface: input byte channel with valid/ready handshake.
`timescale 1ns / 1ps

interface ult_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       last_of_text;

    modport source (output valid, cmd, data_byte, last_of_text, input ready);
    modport sink   (input valid, cmd, data_byte, last_of_text, output ready);
endinterface

/* hw/rtl/ult_out_if.sv */
// Interface: output byte channel with valid/ready handshake.
`timescale 1ns / 1ps

interface ult_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       map_overflow;

    modport source (output valid, out_byte, run_end, map_overflow, input ready);
    modport sink   (input valid, out_byte, run_end, map_overflow, output ready);
endinterface

/* hw/rtl/ult_map_cell.sv */
// Map cell: one dynamic slot holding a code point, with its own compare.
`timescale 1ns / 1ps

module ult_map_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_prev_used,
    input  logic              i_alloc,
    input  ult_pkg::t_code    i_key,
    output ult_pkg::t_cell_stat o_stat,
    output ult_pkg::t_code    o_code
);
    import ult_pkg::*;

    logic  r_used;
    t_code r_entry;
    logic  w_take;

    // The first unused cell in the row claims the allocation.
    assign w_take = i_alloc && i_prev_used && !r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (w_take) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_entry <= i_key;
        end
    end

    assign o_stat.used = r_used;
    assign o_stat.hit  = r_used && (r_entry == i_key);
    assign o_code      = r_used ? r_entry : '0;

endmodule

/* hw/rtl/ult_map_row.sv */
// Map row: chain of slot cells with fill hand-off, match vector and slot read.
`timescale 1ns / 1ps

module ult_map_row (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_alloc,
    input  ult_pkg::t_code                  i_key,
    input  logic [ult_pkg::SLOT_W-1:0]      i_rd_idx,
    output logic [ult_pkg::MAP_SLOTS-1:0]   o_hit,
    output ult_pkg::t_code                  o_rd_code
);
    import ult_pkg::*;

    t_cell_stat w_stat [MAP_SLOTS];
    t_code      w_code [MAP_SLOTS];
    logic       w_prev [MAP_SLOTS];

    genvar g;
    generate
        for (g = 0; g < MAP_SLOTS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev[g] = 1'b1;
            end else begin : g_link
                assign w_prev[g] = w_stat[g-1].used;
            end

            ult_map_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_prev_used (w_prev[g]),
                .i_alloc     (i_alloc),
                .i_key       (i_key),
                .o_stat      (w_stat[g]),
                .o_code      (w_code[g])
            );

            assign o_hit[g] = w_stat[g].hit;
        end
    endgenerate

    // Unused slots read as zero.
    always_comb begin
        o_rd_code = '0;
        for (int i = 0; i < MAP_SLOTS; i++) begin
            if (i_rd_idx == SLOT_W'(i)) begin
                o_rd_code = w_code[i];
            end
        end
    end

endmodule

/* hw/rtl/utf8_latin9_transcoder.sv */
// Top level: byte-serial UTF-8 / Latin-9 transcoder with a dynamic slot row.
//
//  channel    dir  handshake                 payload
//  i_in_ch    in   valid/ready (sink)        cmd, data_byte, last_of_text
//  o_out_ch   out  valid/ready (source)      out_byte, run_end, map_overflow
//
// Steps: an ASCII byte goes to the output register; a completed UTF-8 sequence
// is taken, compared against all slot cells (S_LOOK) and mapped (S_MAP); an encode
// passes S_ENC; then one output byte (1..4) per cycle while the sink is ready.
// One request is in flight at a time: ready is high only in idle.
// Reset is synchronous; the slot cells come up empty through their used bits.
// A stalled output holds its byte until the sink takes it.
`timescale 1ns / 1ps

module utf8_latin9_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ult_in_if.sink      i_in_ch,
    ult_out_if.source   o_out_ch
);
    import ult_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_MAP  = 3'd2;
    localparam logic [2:0] S_ENC  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [2:0]          r_fol, n_fol;
    t_code               r_acc, n_acc;
    logic                r_seqv, n_seqv;
    logic                r_ovf, n_ovf;
    logic [NEXT_W-1:0]   r_next, n_next;
    t_code               r_code, n_code;
    logic                r_last, n_last;
    logic [3:0][7:0]     r_bytes, n_bytes;
    logic [1:0]          r_last_idx, n_last_idx;
    logic [1:0]          r_idx, n_idx;
    logic                r_ovf_out, n_ovf_out;
    logic [MAP_SLOTS-1:0] r_hit;

    logic [MAP_SLOTS-1:0] w_hit;
    t_code               w_rd_code;
    t_code               w_enc_code;
    logic [SLOT_W-1:0]   w_hit_idx;
    logic                w_alloc;
    logic                w_ovf_set;
    logic                w_in_acc;
    logic                w_out_acc;
    logic [7:0]          w_b;
    logic                w_follow_ok;
    logic [7:0]          w_fb;

    assign w_b        = i_in_ch.data_byte;
    assign w_in_acc   = i_in_ch.valid && i_in_ch.ready;
    assign w_out_acc  = o_out_ch.valid && o_out_ch.ready;
    assign w_follow_ok = (w_b[7:6] == 2'b10);
    assign w_fb       = fixed_byte(r_code);

    ult_map_row u_row (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_alloc   (w_alloc),
        .i_key     (r_code),
        .i_rd_idx  (w_b[SLOT_W-1:0]),
        .o_hit     (w_hit),
        .o_rd_code (w_rd_code)
    );

    // Code point of the byte to encode.
    always_comb begin
        if (!w_b[7]) begin
            w_enc_code = {23'd0, w_b};
        end else if (w_b[6:5] == 2'b00) begin
            w_enc_code = w_rd_code;
        end else begin
            w_enc_code = fixed_code(w_b);
        end
    end

    // Slot codes are distinct, so at most one hit bit is set.
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < MAP_SLOTS; i++) begin
            if (r_hit[i]) begin
                w_hit_idx = w_hit_idx | SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fol      = r_fol;
        n_acc      = r_acc;
        n_seqv     = r_seqv;
        n_ovf      = r_ovf;
        n_next     = r_next;
        n_code     = r_code;
        n_last     = r_last;
        n_bytes    = r_bytes;
        n_last_idx = r_last_idx;
        n_idx      = r_idx;
        n_ovf_out  = r_ovf_out;
        w_alloc    = 1'b0;
        w_ovf_set  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_last     = i_in_ch.last_of_text;
                    n_ovf_out  = r_ovf;
                    n_idx      = 2'd0;
                    n_last_idx = 2'd0;
                    if (i_in_ch.cmd) begin
                        n_code  = w_enc_code;
                        n_state = S_ENC;
                    end else if (r_fol != 3'd0) begin
                        // any byte counts as a follower while a sequence is open
                        n_acc  = {r_acc[CODE_W-7:0], w_b[5:0]};
                        n_seqv = r_seqv && w_follow_ok;
                        n_fol  = r_fol - 3'd1;
                        if (r_fol == 3'd1) begin
                            n_acc  = '0;
                            n_seqv = 1'b1;
                            if (r_seqv && w_follow_ok) begin
                                n_code  = {r_acc[CODE_W-7:0], w_b[5:0]};
                                n_state = S_LOOK;
                            end
                        end
                    end else if (!w_b[7]) begin
                        n_bytes[0] = w_b;
                        n_state    = S_EMIT;
                    end else if (w_b[6] && (w_b[7:1] != 7'h7F)) begin
                        n_seqv = 1'b1;
                        if (!w_b[5]) begin
                            n_fol = 3'd1;
                            n_acc = {26'd0, w_b[4:0]};
                        end else if (!w_b[4]) begin
                            n_fol = 3'd2;
                            n_acc = {27'd0, w_b[3:0]};
                        end else if (!w_b[3]) begin
                            n_fol = 3'd3;
                            n_acc = {28'd0, w_b[2:0]};
                        end else if (!w_b[2]) begin
                            n_fol = 3'd4;
                            n_acc = {29'd0, w_b[1:0]};
                        end else begin
                            n_fol = 3'd5;
                            n_acc = {30'd0, w_b[0]};
                        end
                    end
                    // end of text: drop pending sequence; overflow clears after the map
                    if (i_in_ch.last_of_text) begin
                        n_fol  = 3'd0;
                        n_acc  = '0;
                        n_seqv = 1'b1;
                        if (n_state != S_LOOK) begin
                            n_ovf = 1'b0;
                        end
                    end
                end
            end
            S_LOOK: begin
                n_state = S_MAP;
            end
            S_MAP: begin
                n_state = S_EMIT;
                if (r_code[CODE_W-1:8] == '0) begin
                    n_bytes[0] = r_code[7:0];
                end else if (|r_hit) begin
                    n_bytes[0] = {3'b100, w_hit_idx};
                end else if (w_fb != 8'h00) begin
                    n_bytes[0] = w_fb;
                end else if (r_next < NEXT_W'(MAP_SLOTS)) begin
                    n_bytes[0] = {3'b100, r_next[SLOT_W-1:0]};
                    w_alloc    = 1'b1;
                    n_next     = r_next + NEXT_W'(1);
                end else begin
                    n_bytes[0] = 8'hBF;
                    w_ovf_set  = 1'b1;
                end
                n_ovf_out = r_ovf || w_ovf_set;
                n_ovf     = r_last ? 1'b0 : (r_ovf || w_ovf_set);
            end
            S_ENC: begin
                n_state = S_EMIT;
                if (r_code < 31'h80) begin
                    n_bytes[0] = r_code[7:0];
                    n_last_idx = 2'd0;
                end else if (r_code < 31'h800) begin
                    n_bytes[0] = {3'b110, r_code[10:6]};
                    n_bytes[1] = {2'b10, r_code[5:0]};
                    n_last_idx = 2'd1;
                end else if (r_code < 31'h10000) begin
                    n_bytes[0] = {4'b1110, r_code[15:12]};
                    n_bytes[1] = {2'b10, r_code[11:6]};
                    n_bytes[2] = {2'b10, r_code[5:0]};
                    n_last_idx = 2'd2;
                end else begin
                    // wide code points keep their low 21 bits
                    n_bytes[0] = {5'b11110, r_code[20:18]};
                    n_bytes[1] = {2'b10, r_code[17:12]};
                    n_bytes[2] = {2'b10, r_code[11:6]};
                    n_bytes[3] = {2'b10, r_code[5:0]};
                    n_last_idx = 2'd3;
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    if (r_idx == r_last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fol   <= 3'd0;
            r_acc   <= '0;
            r_seqv  <= 1'b1;
            r_ovf   <= 1'b0;
            r_next  <= '0;
        end else begin
            r_state <= n_state;
            r_fol   <= n_fol;
            r_acc   <= n_acc;
            r_seqv  <= n_seqv;
            r_ovf   <= n_ovf;
            r_next  <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_last     <= n_last;
        r_bytes    <= n_bytes;
        r_last_idx <= n_last_idx;
        r_idx      <= n_idx;
        r_ovf_out  <= n_ovf_out;
        r_hit      <= w_hit;
    end

    assign i_in_ch.ready         = (r_state == S_IDLE);
    assign o_out_ch.valid        = (r_state == S_EMIT);
    assign o_out_ch.out_byte     = r_bytes[r_idx];
    assign o_out_ch.run_end      = (r_idx == r_last_idx);
    assign o_out_ch.map_overflow = r_ovf_out;

endmodule

/* hw/rtl/ult_checker.sv */
// Checker: port-level properties of the transcoder, bound to the top level.
`timescale 1ns / 1ps

module ult_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_run_end,
    input logic       i_map_overflow
);

    // No new request is taken while a result is still on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> !i_out_valid)
        else $error("request accepted while output valid");

    // Bytes of one run follow back to back.
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_run_end) |=> i_out_valid)
        else $error("run broken before its last byte");

    // The overflow flag is one value across a run.
    a_ovf_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_run_end) |=> $stable(i_map_overflow))
        else $error("overflow flag changed inside a run");

    // A stalled byte holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)))
        else $error("stalled output byte changed");

endmodule

bind utf8_latin9_transcoder ult_checker u_ult_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_ch.valid),
    .i_in_ready     (i_in_ch.ready),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_out_byte     (o_out_ch.out_byte),
    .i_run_end      (o_out_ch.run_end),
    .i_map_overflow (o_out_ch.map_overflow)
);

/* verif/tb.sv */
// Self-checking testbench for the UTF-8 / Latin-9 transcoder: directed table plus random text.
`timescale 1ns / 1ps

module tb;

    import ult_pkg::MAP_SLOTS;

    typedef enum bit {
        OP_DECODE = 1'b0,
        OP_ENCODE = 1'b1
    } t_op;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       map_ovf;
    } t_out_item;

    typedef struct {
        t_op        op;
        bit [7:0]   data;
        bit         last;
        int         typed_n;
        bit [7:0]   typed_b;
    } t_row;

    localparam int USE_PREDICTION = -1;
    localparam int N_DIRECTED     = 29;
    localparam int N_RANDOM       = 200;
    localparam int CYCLE_LIMIT    = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ult_in_if  in_ch ();
    ult_out_if out_ch ();

    utf8_latin9_transcoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state, mirrors the block after reset.
    bit [2:0]  pend_cnt  = '0;
    bit [30:0] acc_code  = '0;
    bit        seq_ok    = 1'b1;
    bit [30:0] slot_code [32];
    bit [5:0]  slot_next = '0;
    bit        ovf_seen  = 1'b0;

    t_out_item bytes_due [$];
    t_out_item want_item;
    int        mismatch_cnt = 0;
    int        reqs_sent    = 0;
    int        cycle_cnt    = 0;
    int        src_idle_pct = 17;
    int        snk_stall_pct = 51;

    t_row dir_rows [N_DIRECTED] = '{
        '{OP_DECODE, 8'h00, 1'b0, 1, 8'h00},
        '{OP_DECODE, 8'h7F, 1'b0, 1, 8'h7F},
        '{OP_DECODE, 8'h80, 1'b0, 0, 8'h00},
        '{OP_DECODE, 8'hFE, 1'b0, 0, 8'h00},
        '{OP_DECODE, 8'hFF, 1'b0, 0, 8'h00},
        // euro sign through the fixed table
        '{OP_DECODE, 8'hE2, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'h82, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hAC, 1'b0, USE_PREDICTION, 8'h00},
        // bad follower kills the sequence
        '{OP_DECODE, 8'hC3, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'h41, 1'b0, 0, 8'h00},
        // overlong form
        '{OP_DECODE, 8'hC1, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hBF, 1'b0, USE_PREDICTION, 8'h00},
        // first dynamic slot
        '{OP_DECODE, 8'hE4, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hB8, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hAD, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_ENCODE, 8'h80, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_ENCODE, 8'h81, 1'b0, 1, 8'h00},
        '{OP_ENCODE, 8'hA4, 1'b0, USE_PREDICTION, 8'h00},
        // six-byte form, widest code point, then truncated on encode
        '{OP_DECODE, 8'hFD, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hBF, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hBF, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hBF, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hBF, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hBF, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_ENCODE, 8'h81, 1'b0, USE_PREDICTION, 8'h00},
        // encode in the middle of a pending sequence
        '{OP_DECODE, 8'hC3, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_ENCODE, 8'hFF, 1'b0, USE_PREDICTION, 8'h00},
        '{OP_DECODE, 8'hA9, 1'b0, USE_PREDICTION, 8'h00},
        // text ends inside a sequence
        '{OP_DECODE, 8'hE2, 1'b1, 0, 8'h00}
    };

    function automatic void fixed_pair(input int idx, output bit [7:0] b,
                                       output bit [30:0] code);
        case (idx)
            0:       begin b = 8'hA4; code = 31'h20AC; end
            1:       begin b = 8'hA6; code = 31'h0160; end
            2:       begin b = 8'hA8; code = 31'h0161; end
            3:       begin b = 8'hB4; code = 31'h017D; end
            4:       begin b = 8'hB8; code = 31'h017E; end
            5:       begin b = 8'hBC; code = 31'h0152; end
            6:       begin b = 8'hBD; code = 31'h0153; end
            default: begin b = 8'hBE; code = 31'h0178; end
        endcase
    endfunction

    function automatic bit [7:0] latin9_of(input bit [30:0] code);
        bit [7:0]  fb;
        bit [30:0] fc;
        bit [7:0]  slot_b;
        for (int i = 0; i < int'(slot_next) && i < MAP_SLOTS; i++)
            if (code >= 31'd256 && slot_code[i] == code)
                return 8'h80 + 8'(i);
        if (code < 31'd256)
            return code[7:0];
        for (int i = 0; i < 8; i++) begin
            fixed_pair(i, fb, fc);
            if (fc == code)
                return fb;
        end
        if (int'(slot_next) < MAP_SLOTS) begin
            slot_code[slot_next[4:0]] = code;
            slot_b = 8'h80 + {2'b00, slot_next};
            slot_next = slot_next + 6'd1;
            return slot_b;
        end
        ovf_seen = 1'b1;
        return 8'hBF;
    endfunction

    function automatic bit [30:0] code_of(input bit [7:0] b);
        bit [7:0]  fb;
        bit [30:0] fc;
        if (b < 8'h80)
            return {23'd0, b};
        if (b < 8'hA0)
            return slot_code[b[4:0]];
        for (int i = 0; i < 8; i++) begin
            fixed_pair(i, fb, fc);
            if (fb == b)
                return fc;
        end
        return {23'd0, b};
    endfunction

    // Advance the predictor by one request; return the bytes it yields.
    function automatic void transcode_byte(input t_op op, input bit [7:0] b, input bit l,
                                           output int n, output bit [3:0][7:0] o,
                                           output bit ovf);
        bit [30:0] cp;
        n = 0;
        o = '0;
        if (op == OP_DECODE) begin
            if (pend_cnt != 3'd0) begin
                if (b[7:6] != 2'b10)
                    seq_ok = 1'b0;
                acc_code = {acc_code[24:0], b[5:0]};
                pend_cnt = pend_cnt - 3'd1;
                if (pend_cnt == 3'd0) begin
                    if (seq_ok) begin
                        o[0] = latin9_of(acc_code);
                        n = 1;
                    end
                    seq_ok = 1'b1;
                    acc_code = '0;
                end
            end else if (b < 8'h80) begin
                o[0] = b;
                n = 1;
            end else if (b >= 8'hC0 && b < 8'hFE) begin
                seq_ok = 1'b1;
                if (b < 8'hE0) begin
                    pend_cnt = 3'd1; acc_code = {26'd0, b[4:0]};
                end else if (b < 8'hF0) begin
                    pend_cnt = 3'd2; acc_code = {27'd0, b[3:0]};
                end else if (b < 8'hF8) begin
                    pend_cnt = 3'd3; acc_code = {28'd0, b[2:0]};
                end else if (b < 8'hFC) begin
                    pend_cnt = 3'd4; acc_code = {29'd0, b[1:0]};
                end else begin
                    pend_cnt = 3'd5; acc_code = {30'd0, b[0]};
                end
            end
        end else begin
            cp = code_of(b);
            if (cp < 31'h80) begin
                o[0] = cp[7:0];
                n = 1;
            end else if (cp < 31'h800) begin
                o[0] = {3'b110, cp[10:6]};
                o[1] = {2'b10, cp[5:0]};
                n = 2;
            end else if (cp < 31'h10000) begin
                o[0] = {4'b1110, cp[15:12]};
                o[1] = {2'b10, cp[11:6]};
                o[2] = {2'b10, cp[5:0]};
                n = 3;
            end else begin
                // keep only 21 bits in the four-byte form
                o[0] = {5'b11110, cp[20:18]};
                o[1] = {2'b10, cp[17:12]};
                o[2] = {2'b10, cp[11:6]};
                o[3] = {2'b10, cp[5:0]};
                n = 4;
            end
        end
        ovf = ovf_seen;
        if (l) begin
            pend_cnt = '0;
            acc_code = '0;
            seq_ok = 1'b1;
            ovf_seen = 1'b0;
        end
    endfunction

    task automatic queue_bytes(input int n, input bit [3:0][7:0] o, input bit ovf);
        t_out_item it;
        for (int k = 0; k < n; k++) begin
            it.ch = o[k];
            it.run_end = (k == n - 1);
            it.map_ovf = ovf;
            bytes_due.push_back(it);
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    // Predict, then hold the request until the block takes it.
    task automatic send_req(input t_op op, input bit [7:0] b, input bit l,
                            input int typed_n, input bit [7:0] typed_b);
        int              n;
        bit [3:0][7:0]   o;
        bit              ovf;
        if (reqs_sent < N_DIRECTED + N_RANDOM / 3) begin
            src_idle_pct = 17; snk_stall_pct = 51;
        end else if (reqs_sent < N_DIRECTED + 2 * N_RANDOM / 3) begin
            src_idle_pct = 51; snk_stall_pct = 17;
        end else begin
            src_idle_pct = 0; snk_stall_pct = 0;
        end
        transcode_byte(op, b, l, n, o, ovf);
        if (typed_n == USE_PREDICTION) begin
            queue_bytes(n, o, ovf);
        end else begin
            o = '0;
            o[0] = typed_b;
            queue_bytes(typed_n, o, 1'b0);
        end
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= op;
        in_ch.data_byte    <= b;
        in_ch.last_of_text <= l;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        reqs_sent++;
    endtask

    // Emit a UTF-8 form of len bytes; cut it short or corrupt one follower as asked,
    // and at random slip an encode request between bytes.
    task automatic send_utf8(input bit [30:0] code, input int len, input int bad_pos,
                             input int cut, input bit l);
        bit [7:0]  pfx;
        bit [7:0]  v;
        bit [30:0] sh;
        case (len)
            2:       pfx = 8'hC0;
            3:       pfx = 8'hE0;
            4:       pfx = 8'hF0;
            5:       pfx = 8'hF8;
            default: pfx = 8'hFC;
        endcase
        for (int k = 0; k < cut; k++) begin
            sh = code >> (6 * (len - 1 - k));
            if (k == 0) begin
                v = pfx | sh[7:0];
            end else if (k == bad_pos) begin
                v = 8'($urandom_range(255));
                while (v[7:6] == 2'b10)
                    v = 8'($urandom_range(255));
            end else begin
                v = {2'b10, sh[5:0]};
            end
            if (k > 0 && $urandom_range(9) == 0)
                send_req(OP_ENCODE, 8'($urandom_range(255)), 1'b0, USE_PREDICTION, 8'h00);
            send_req(OP_DECODE, v, l && (k == cut - 1), USE_PREDICTION, 8'h00);
        end
    endtask

    function automatic bit [30:0] rand_code(input int len);
        bit [31:0] mask;
        bit [31:0] r;
        mask = (32'd1 << (5 * len + 1)) - 32'd1;
        r = $urandom & mask;
        return r[30:0];
    endfunction

    always @(negedge i_clk)
        if (i_rst_n)
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (bytes_due.size() == 0) begin
                flag_mismatch("unexpected byte", out_ch.out_byte, 0);
            end else begin
                want_item = bytes_due.pop_front();
                if (out_ch.out_byte !== want_item.ch)
                    flag_mismatch("out_byte", out_ch.out_byte, want_item.ch);
                if (out_ch.run_end !== want_item.run_end)
                    flag_mismatch("run_end", out_ch.run_end, want_item.run_end);
                if (out_ch.map_overflow !== want_item.map_ovf)
                    flag_mismatch("map_overflow", out_ch.map_overflow, want_item.map_ovf);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int        r;
        int        len;
        bit        l;
        bit [30:0] code;
        bit [7:0]  b;

        for (int i = 0; i < 32; i++)
            slot_code[i] = '0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = OP_DECODE;
        in_ch.data_byte    = 8'h00;
        in_ch.last_of_text = 1'b0;
        out_ch.ready       = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_req(dir_rows[i].op, dir_rows[i].data, dir_rows[i].last,
                     dir_rows[i].typed_n, dir_rows[i].typed_b);

        while (reqs_sent < N_DIRECTED + N_RANDOM) begin
            r = $urandom_range(99);
            l = ($urandom_range(15) == 0);
            if (r < 10) begin
                send_req(OP_DECODE, 8'($urandom_range(127)), l, USE_PREDICTION, 8'h00);
            end else if (r < 26) begin
                send_utf8(rand_code(2), 2, 0, 2, l);
            end else if (r < 42) begin
                // reuse a few code points so slot hits show up
                case ($urandom_range(7))
                    0:       code = 31'h4E2D;
                    1:       code = 31'h3042;
                    2:       code = 31'h20AC;
                    3:       code = 31'h0178;
                    4:       code = 31'h0394;
                    default: code = rand_code(3);
                endcase
                send_utf8(code, 3, 0, 3, l);
            end else if (r < 54) begin
                send_utf8(rand_code(4), 4, 0, 4, l);
            end else if (r < 62) begin
                len = $urandom_range(5, 6);
                send_utf8(rand_code(len), len, 0, len, l);
            end else if (r < 68) begin
                len = $urandom_range(2, 6);
                send_utf8(rand_code(len), len, $urandom_range(1, len - 1), len, l);
            end else if (r < 73) begin
                b = $urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                      : 8'($urandom_range(8'hFE, 8'hFF));
                send_req(OP_DECODE, b, l, USE_PREDICTION, 8'h00);
            end else if (r < 88) begin
                b = $urandom_range(1) ? 8'($urandom_range(8'h80, 8'h9F))
                                      : 8'($urandom_range(255));
                send_req(OP_ENCODE, b, l, USE_PREDICTION, 8'h00);
            end else begin
                len = $urandom_range(2, 6);
                send_utf8(rand_code(len), len, 0, $urandom_range(1, len - 1), 1'b1);
            end
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && bytes_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ult_pkg.sv
hw/rtl/ult_in_if.sv
hw/rtl/ult_out_if.sv
hw/rtl/ult_map_cell.sv
hw/rtl/ult_map_row.sv
hw/rtl/utf8_latin9_transcoder.sv
hw/rtl/ult_checker.sv
verif/tb.sv
